### sv/tocq_pkg.sv
// Shared types and constants for the tick-ordered command queue.
package tocq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int TICK_W            = 64;
  localparam int PLAYER_W          = 8;
  localparam int SEQ_W             = 32;
  localparam int PAY_PORT_W        = 32;
  localparam int LIMIT_W           = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [1:0] MODE_TAKE     = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] STAT_ACCEPTED = 3'd0;
  localparam logic [2:0] STAT_PAST     = 3'd1;
  localparam logic [2:0] STAT_DUP      = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_TAKEN    = 3'd4;
  localparam logic [2:0] STAT_NONE     = 3'd5;
  localparam logic [2:0] STAT_CLEARED  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_TK_RD,
    S_TK_CHK,
    S_EM_RD,
    S_EM_OUT,
    S_CMP_RD,
    S_CMP_WR,
    S_FIN,
    S_RES
  } state_t;

endpackage

### sv/tocq_cmd_if.sv
// Command channel interface.
interface tocq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] command_tick;
  logic [63:0] reference_tick;
  logic [7:0]  player_id;
  logic [31:0] sequence_number;
  logic [31:0] command_payload;
  modport source (output valid, mode, command_tick, reference_tick, player_id,
                  sequence_number, command_payload, input ready);
  modport sink (input valid, mode, command_tick, reference_tick, player_id,
                sequence_number, command_payload, output ready);
endinterface

### sv/tocq_res_if.sv
// Result channel interface.
interface tocq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_tick;
  logic [7:0]  out_player;
  logic [31:0] out_sequence;
  logic [31:0] out_payload;
  logic        last_of_run;
  logic [4:0]  occupancy;
  logic        late_seen;
  modport source (output valid, status, out_tick, out_player, out_sequence, out_payload,
                  last_of_run, occupancy, late_seen, input ready);
  modport sink (input valid, status, out_tick, out_player, out_sequence, out_payload,
                last_of_run, occupancy, late_seen, output ready);
endinterface

### sv/tocq_cfg_if.sv
// Configuration write channel interface.
interface tocq_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/tocq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tocq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sv/tick_ordered_command_queue.sv
// Tick-ordered command queue: sorted store in RAM, sequenced read-modify-write.
// Sequence: schedule scans every held entry for a duplicate and the insert position,
//   shifts the entries behind that position on insert, then answers (a reject skips
//   the insert, a past tick the scan too); take scans through the matching run and
//   the first later entry, emits each taken entry, then compacts the entries behind it.
// Throughput: one command at a time; the single RAM read port sets the pace.
// Reset: synchronous; clears count, late flag and sequencer; limit returns to 16.
module tick_ordered_command_queue #(
  parameter int CAPACITY      = tocq_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = tocq_pkg::PAYLOAD_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  tocq_cmd_if.sink   cmd,
  tocq_res_if.source res,
  tocq_cfg_if.sink   cfg
);
  import tocq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int PK = (PAYLOAD_WIDTH < PAY_PORT_W) ? PAYLOAD_WIDTH : PAY_PORT_W;
  localparam int WW = TICK_W + PLAYER_W + SEQ_W + PAYLOAD_WIDTH;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  // sequencer and control
  state_t state, state_next;
  logic [CW-1:0] count;
  logic          late;
  logic [LIMIT_W-1:0] capacity_limit;

  // latched command
  logic [1:0]          c_mode;
  logic [TICK_W-1:0]   c_tick, c_ref;
  logic [PLAYER_W-1:0] c_player;
  logic [SEQ_W-1:0]    c_seq;
  logic [PAY_PORT_W-1:0] c_pay;

  // scan bookkeeping
  logic [CW-1:0] idx, pos, first, n, k;
  logic          dup, found;
  logic [2:0]    res_code;

  // RAM
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;

  logic [TICK_W-1:0]        r_tick;
  logic [PLAYER_W-1:0]      r_player;
  logic [SEQ_W-1:0]         r_seq;
  logic [PAYLOAD_WIDTH-1:0] r_pay;
  assign {r_tick, r_player, r_seq, r_pay} = rdata;

  logic accept, slot_free, load_res, scan_last, tk_stop, tk_eq, em_last, over_limit;
  logic [LW-1:0] limit_eff;
  logic [CW-1:0] idx_inc, idx_dec, n_total;

  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !res.valid || res.ready;
  assign idx_inc   = CW'(idx + 1'b1);
  assign idx_dec   = CW'(idx - 1'b1);
  assign scan_last = (idx_inc == count);
  assign tk_eq     = (r_tick == c_ref);
  assign tk_stop   = (r_tick > c_ref) || scan_last;
  assign n_total   = CW'(n + {{(CW-1){1'b0}}, tk_eq});
  assign em_last   = (CW'(k + 1'b1) == n);
  assign limit_eff = (LW'(capacity_limit) < CAP_L) ? LW'(capacity_limit) : CAP_L;
  assign over_limit = (LW'(count) >= limit_eff);

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);

  tocq_ram #(.WIDTH(WW), .DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            MODE_SCHEDULE: begin
              if (cmd.command_tick < cmd.reference_tick) state_next = S_RES;
              else if (count == '0)                      state_next = S_DECIDE;
              else                                       state_next = S_SCAN_RD;
            end
            MODE_TAKE:  state_next = (count == '0) ? S_RES : S_TK_RD;
            MODE_CLEAR: state_next = S_RES;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = scan_last ? S_DECIDE : S_SCAN_RD;
      S_DECIDE: begin
        if (dup || over_limit) state_next = S_RES;
        else if (count == pos) state_next = S_INS;
        else                   state_next = S_SH_RD;
      end
      S_SH_RD:  state_next = S_SH_WR;
      S_SH_WR:  state_next = (idx_dec == pos) ? S_INS : S_SH_RD;
      S_INS:    state_next = S_RES;
      S_TK_RD:  state_next = S_TK_CHK;
      S_TK_CHK: begin
        if (tk_stop) state_next = (n_total == '0) ? S_RES : S_EM_RD;
        else         state_next = S_TK_RD;
      end
      S_EM_RD: state_next = S_EM_OUT;
      S_EM_OUT: begin
        if (slot_free) begin
          if (!em_last)                          state_next = S_EM_RD;
          else if (CW'(first + n) == count)      state_next = S_FIN;
          else                                   state_next = S_CMP_RD;
        end
      end
      S_CMP_RD: state_next = S_CMP_WR;
      S_CMP_WR: state_next = scan_last ? S_FIN : S_CMP_RD;
      S_FIN:    state_next = S_IDLE;
      S_RES:    state_next = slot_free ? S_IDLE : S_RES;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM control and result load
  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx[AW-1:0];
    raddr    = idx[AW-1:0];
    wdata    = rdata;
    load_res = 1'b0;
    case (state)
      S_SCAN_RD, S_TK_RD, S_CMP_RD: re = 1'b1;
      S_SH_RD: begin
        re    = 1'b1;
        raddr = idx_dec[AW-1:0];
      end
      S_SH_WR: we = 1'b1;
      S_INS: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = {c_tick, c_player, c_seq, PAYLOAD_WIDTH'(c_pay[PK-1:0])};
      end
      S_EM_RD: begin
        re    = 1'b1;
        raddr = AW'(first + k);
      end
      S_EM_OUT: load_res = slot_free;
      S_CMP_WR: begin
        we    = 1'b1;
        waddr = AW'(idx - n);
      end
      S_RES: load_res = slot_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      late           <= 1'b0;
      capacity_limit <= LIMIT_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) capacity_limit <= cfg.data;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.mode == MODE_CLEAR) begin
              count <= '0;
              late  <= 1'b0;
            end else if (cmd.mode == MODE_SCHEDULE &&
                         cmd.command_tick < cmd.reference_tick) begin
              late <= 1'b1;
            end
          end
        end
        S_INS: count <= CW'(count + 1'b1);
        S_FIN: count <= CW'(count - n);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        c_mode   <= cmd.mode;
        c_tick   <= cmd.command_tick;
        c_ref    <= cmd.reference_tick;
        c_player <= cmd.player_id;
        c_seq    <= cmd.sequence_number;
        c_pay    <= cmd.command_payload;
        idx      <= '0;
        pos      <= count;
        first    <= '0;
        n        <= '0;
        k        <= '0;
        dup      <= 1'b0;
        found    <= 1'b0;
        case (cmd.mode)
          MODE_SCHEDULE: res_code <= STAT_PAST;
          MODE_TAKE:     res_code <= STAT_NONE;
          default:       res_code <= STAT_CLEARED;
        endcase
      end
      S_SCAN_CHK: begin
        if (r_player == c_player && r_seq == c_seq) dup <= 1'b1;
        if (!found && r_tick > c_tick) begin
          found <= 1'b1;
          pos   <= idx;
        end
        idx <= idx_inc;
      end
      S_DECIDE: begin
        idx <= count;
        if (dup)             res_code <= STAT_DUP;
        else if (over_limit) res_code <= STAT_FULL;
        else                 res_code <= STAT_ACCEPTED;
      end
      S_SH_WR: idx <= idx_dec;
      S_TK_CHK: begin
        // sorted store: entries below the tick precede the matching run
        if (r_tick < c_ref) first <= idx_inc;
        n   <= n_total;
        idx <= idx_inc;
      end
      S_EM_OUT: begin
        if (slot_free) begin
          k   <= CW'(k + 1'b1);
          idx <= CW'(first + n);
        end
      end
      S_CMP_WR: idx <= idx_inc;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_res) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.late_seen <= late;
      if (state == S_EM_OUT) begin
        res.status       <= STAT_TAKEN;
        res.out_tick     <= r_tick;
        res.out_player   <= r_player;
        res.out_sequence <= r_seq;
        res.out_payload  <= PAY_PORT_W'(r_pay[PK-1:0]);
        res.last_of_run  <= em_last;
        res.occupancy    <= LIMIT_W'(CW'(count - n));
      end else begin
        res.status       <= res_code;
        res.out_tick     <= '0;
        res.out_player   <= '0;
        res.out_sequence <= '0;
        res.out_payload  <= '0;
        res.last_of_run  <= 1'b1;
        res.occupancy    <= LIMIT_W'(count);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count above capacity");
  a_ins_inc: assert property (@(posedge clk) disable iff (rst)
    state == S_INS |=> count == CW'($past(count) + 1'b1)) else $error("insert count");
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SH_WR || state == S_INS || state == S_CMP_WR))
    else $error("stray RAM write");
  a_take_mode: assert property (@(posedge clk) disable iff (rst)
    state == S_EM_OUT |-> c_mode == MODE_TAKE && n != '0) else $error("emit outside take");
`endif
endmodule

### tb/sv/tocq_sb.sv
// Scoreboard for the tick-ordered command queue: sorted-store predictor and result check.
class tocq_sb;
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] tick;
    logic [7:0]  player;
    logic [31:0] seq;
    logic [31:0] payload;
    logic        last;
    logic [4:0]  occupancy;
    logic        late;
  } result_t;

  typedef struct packed {
    logic [63:0] tick;
    logic [7:0]  player;
    logic [31:0] seq;
    logic [31:0] payload;
  } entry_t;

  entry_t    held[$];
  logic [4:0] limit;
  logic      late;
  result_t   pending[$];
  int        errors;

  function new();
    limit = tocq_pkg::LIMIT_RESET;
    late = 1'b0;
    errors = 0;
  endfunction

  function void set_limit(logic [4:0] v);
    limit = v;
  endfunction

  function int outstanding();
    return pending.size();
  endfunction

  function int held_count();
    return held.size();
  endfunction

  function void push_status(logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    r.occupancy = 5'(held.size());
    r.late = late;
    pending.insert(pending.size(), r);
  endfunction

  // Note an accepted command transaction and queue the results it must give.
  function void note_command(logic [1:0] mode, logic [63:0] ctick, logic [63:0] rtick,
                             logic [7:0] player, logic [31:0] seq, logic [31:0] pay);
    int eff, pos, first, stop;
    bit dup;
    entry_t e;
    entry_t taken[$];
    result_t r;
    eff = (limit > tocq_pkg::CAPACITY_DEF) ? tocq_pkg::CAPACITY_DEF : limit;
    case (mode)
      tocq_pkg::MODE_SCHEDULE: begin
        dup = 0;
        foreach (held[i]) if (held[i].player == player && held[i].seq == seq) dup = 1;
        if (ctick < rtick) begin
          late = 1'b1;
          push_status(tocq_pkg::STAT_PAST);
        end else if (dup) begin
          push_status(tocq_pkg::STAT_DUP);
        end else if (held.size() >= eff) begin
          push_status(tocq_pkg::STAT_FULL);
        end else begin
          pos = held.size();
          for (int i = 0; i < held.size(); i++)
            if (held[i].tick > ctick) begin
              pos = i;
              break;
            end
          e.tick = ctick;
          e.player = player;
          e.seq = seq;
          e.payload = pay;
          held.insert(pos, e);
          push_status(tocq_pkg::STAT_ACCEPTED);
        end
      end
      tocq_pkg::MODE_TAKE: begin
        first = 0;
        while (first < held.size() && held[first].tick < rtick) first++;
        stop = first;
        while (stop < held.size() && held[stop].tick == rtick) stop++;
        if (stop == first) begin
          push_status(tocq_pkg::STAT_NONE);
        end else begin
          for (int i = first; i < stop; i++) taken.insert(taken.size(), held[i]);
          for (int i = first; i < stop; i++) held.delete(first);
          foreach (taken[i]) begin
            r.status = tocq_pkg::STAT_TAKEN;
            r.tick = taken[i].tick;
            r.player = taken[i].player;
            r.seq = taken[i].seq;
            r.payload = taken[i].payload;
            r.last = (i == taken.size() - 1);
            r.occupancy = 5'(held.size());
            r.late = late;
            pending.insert(pending.size(), r);
          end
        end
      end
      tocq_pkg::MODE_CLEAR: begin
        held.delete();
        late = 1'b0;
        push_status(tocq_pkg::STAT_CLEARED);
      end
      default: ;
    endcase
  endfunction

  // Compare one accepted result transaction against the oldest expectation.
  function void check_result(result_t got);
    result_t exp;
    if (pending.size() == 0) begin
      $error("unexpected result transaction, status %0d", got.status);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
    end
    if (got.tick !== exp.tick) begin
      $error("out_tick: expected %0h, got %0h", exp.tick, got.tick); errors++;
    end
    if (got.player !== exp.player) begin
      $error("out_player: expected %0h, got %0h", exp.player, got.player); errors++;
    end
    if (got.seq !== exp.seq) begin
      $error("out_sequence: expected %0h, got %0h", exp.seq, got.seq); errors++;
    end
    if (got.payload !== exp.payload) begin
      $error("out_payload: expected %0h, got %0h", exp.payload, got.payload); errors++;
    end
    if (got.last !== exp.last) begin
      $error("last_of_run: expected %0b, got %0b", exp.last, got.last); errors++;
    end
    if (got.occupancy !== exp.occupancy) begin
      $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy); errors++;
    end
    if (got.late !== exp.late) begin
      $error("late_seen: expected %0b, got %0b", exp.late, got.late); errors++;
    end
  endfunction
endclass

### tb/sv/tb.sv
// Testbench top: drives the tick-ordered command queue and checks every result.
module tb;
  import tocq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tocq_cmd_if cmd();
  tocq_res_if res();
  tocq_cfg_if cfg();

  tick_ordered_command_queue u_top (.clk(clk), .rst(rst), .cmd(cmd), .res(res), .cfg(cfg));

  tocq_sb sb = new();

  // Drain stall: set by the stimulus, counted and cleared by the result side.
  bit   hold_results = 0;
  int   cycle = 0;
  bit   stim_done = 0;
  logic [63:0] now_tick;  // game-time cursor used by the random phase
  logic [7:0]  cur_player;
  logic [31:0] cur_seq;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.mode = MODE_SCHEDULE;
    cmd.command_tick = '0;
    cmd.reference_tick = '0;
    cmd.player_id = '0;
    cmd.sequence_number = '0;
    cmd.command_payload = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    res.ready = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result monitor: check on handshake.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      sb.check_result({res.status, res.out_tick, res.out_player, res.out_sequence,
                       res.out_payload, res.last_of_run, res.occupancy, res.late_seen});
    end
  end

  // Result side: random ready per transaction, long hold counted here on request.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (rst) begin
        res.ready <= 1'b0;
        @(negedge clk);
      end else if (hold_results) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          res.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        res.ready <= 1'b1;
        // Stay ready until one transaction completes or a hold is requested.
        do @(posedge clk); while (!(res.valid && res.ready) && !hold_results);
        @(negedge clk);
      end
    end
  end

  // One command transaction; sender gap drawn per item. Valid stays high after
  // acceptance only until the next call or wait_idle changes it.
  task automatic send_cmd(logic [1:0] mode, logic [63:0] ctick, logic [63:0] rtick,
                          logic [7:0] player, logic [31:0] seq, logic [31:0] pay,
                          bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.mode <= mode;
    cmd.command_tick <= ctick;
    cmd.reference_tick <= rtick;
    cmd.player_id <= player;
    cmd.sequence_number <= seq;
    cmd.command_payload <= pay;
    do @(posedge clk); while (!cmd.ready);
    sb.note_command(mode, ctick, rtick, player, seq, pay);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the sequencer settle.
  task automatic wait_idle();
    cmd.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    sb.set_limit(v);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Short-hand for a fresh schedule with a unique key.
  task automatic sched(logic [63:0] ctick, logic [63:0] rtick, bit no_gap = 0);
    cur_seq = cur_seq + 1;
    send_cmd(MODE_SCHEDULE, ctick, rtick, cur_player, cur_seq, $urandom(), no_gap);
  endtask

  // Random phase: mostly well-formed game traffic around a moving tick cursor.
  task automatic random_item();
    int sel;
    logic [63:0] t;
    sel = $urandom_range(0, 99);
    cur_player = 8'($urandom());
    if (sel < 55) begin
      t = now_tick + $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) t = now_tick - 1;        // late command
      cur_seq = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom();
      cur_player = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : cur_player;
      send_cmd(MODE_SCHEDULE, t, now_tick, cur_player, cur_seq, $urandom());
    end else if (sel < 88) begin
      send_cmd(MODE_TAKE, '0, now_tick + $urandom_range(0, 2), '0, '0, '0);
      if ($urandom_range(0, 1) == 0) now_tick = now_tick + 1;
    end else if (sel < 92) begin
      send_cmd(MODE_CLEAR, '0, '0, '0, '0, '0);
    end else if (sel < 94) begin
      // Unused mode: no result expected, still exercises the ignore path.
      send_cmd(MODE_RESERVED, {$urandom(), $urandom()}, {$urandom(), $urandom()},
               8'($urandom()), $urandom(), $urandom());
    end else begin
      // Noise across full field ranges.
      send_cmd(MODE_SCHEDULE, {$urandom(), $urandom()}, {$urandom(), $urandom()},
               8'($urandom()), $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [63:0] maxt;
    maxt = '1;
    now_tick = 64'd100;
    cur_player = 8'd0;
    cur_seq = 32'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, every mode, the listed corner cases.
    sched(64'd0, 64'd0);                                     // tick zero, equal ref
    send_cmd(MODE_SCHEDULE, maxt, 64'd5, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_SCHEDULE, 64'd7, 64'd0, 8'hFF, 32'hFFFF_FFFF, 32'h0); // duplicate
    send_cmd(MODE_SCHEDULE, 64'd4, maxt, 8'h00, 32'h0, 32'hA5A5_5A5A);  // past tick
    sched(64'd7, 64'd0);
    sched(64'd7, 64'd0);                                     // same tick, arrival order
    sched(64'd3, 64'd0);
    send_cmd(MODE_TAKE, '0, 64'd5, '0, '0, '0);              // nothing at tick 5
    send_cmd(MODE_TAKE, '0, 64'd7, '0, '0, '0);              // run of two past stale ones
    send_cmd(MODE_TAKE, '0, maxt, '0, '0, '0);
    send_cmd(MODE_RESERVED, maxt, maxt, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_CLEAR, '0, '0, '0, '0, '0);
    write_limit(5'd0);                                       // limit zero: always full
    sched(64'd9, 64'd0);
    send_cmd(MODE_SCHEDULE, 64'd1, 64'd2, 8'h1, 32'h1, 32'h1); // past still wins
    write_limit(5'd31);                                      // above capacity
    for (int i = 0; i < 17; i++) sched(64'd50, 64'd0, 1);    // fill, then full
    send_cmd(MODE_TAKE, '0, 64'd50, '0, '0, '0);             // sixteen results

    // Fill while the result side holds off: block must back-pressure commands.
    wait_idle();
    hold_results = 1;
    for (int i = 0; i < 8; i++) sched(64'd60 + i, 64'd0, 1);

    for (int i = 0; i < 500; i++) begin
      if (i % 100 == 0)
        write_limit(($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(1, 31)));
      if (i == 250) wait_idle();                             // sender pause to empty
      random_item();
    end
    write_limit(5'd16);

    while (sb.outstanding() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
